### src/cde_pkg.sv
// shared types, constants and calendar tables for the date to epoch seconds block
// no dependencies
package cde_pkg;

  localparam int unsigned DAYS_W = 25;
  localparam int unsigned SECS_W = 41;
  localparam int unsigned HMS_W  = 17;

  localparam logic [15:0] EPOCH_YEAR         = 16'd1970;
  localparam logic [13:0] LEAPS_BEFORE_EPOCH = 14'd477;
  localparam logic [8:0]  DAYS_PER_YEAR      = 9'd365;
  localparam logic [16:0] SECS_PER_DAY       = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR      = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN       = 6'd60;
  localparam logic [15:0] RECIP25            = 16'd41944;
  localparam int unsigned RECIP25_SHIFT      = 20;
  localparam logic [4:0]  DIV25              = 5'd25;

  localparam logic [7:0] MONTH_JAN  = 8'd1;
  localparam logic [7:0] MONTH_FEB  = 8'd2;
  localparam logic [7:0] MONTH_DEC  = 8'd12;
  localparam logic [7:0] HOUR_MAX   = 8'd23;
  localparam logic [7:0] MINSEC_MAX = 8'd59;

  typedef struct packed {
    logic [15:0] year;
    logic [7:0]  month;
    logic [7:0]  day_of_month;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
  } cde_in_t;

  typedef struct packed {
    logic [SECS_W-1:0] epoch_seconds;
    logic              invalid;
  } cde_out_t;

  typedef struct packed {
    logic a;
    logic b;
    logic c;
  } cde_adv_t;

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before_month(input logic [3:0] m);
    logic [8:0] d;
    unique case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

### src/calendar_date_to_epoch_seconds.sv
// top level: utc calendar date and time to seconds since 1970-01-01 00:00:00
// depends on cde_pkg and cde_day_count
//
// usage:
//   in_valid/in_ready/in_data carry one date and time per beat (cde_in_t);
//   out_valid/out_ready/out_data carry epoch_seconds and the invalid flag
//   (cde_out_t), exactly one result beat per input beat, in order.
//   throughput is one beat per cycle while out_ready stays high; the five stages run concurrently.
//   the stages are: divide-by-25 reciprocal multiplies, leap rule and day of
//   year, day count, days times 86400, final sum with the invalid mux.
//   a failed field check gives epoch_seconds zero and invalid high.
//   each stage holds its beat while the next is full and stalled, so
//   out_ready low backs up to in_ready; empty stages still fill, so bubbles
//   close up. reset empties the pipe; no beat is lost or repeated on stall.
//
module calendar_date_to_epoch_seconds (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cde_pkg::cde_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cde_pkg::cde_out_t out_data
);
  import cde_pkg::*;

  localparam int unsigned NSTAGE = 5;

  logic [NSTAGE-1:0] vld_r;
  logic [NSTAGE-1:0] vld_nxt;
  logic [NSTAGE-1:0] rdy;
  cde_adv_t          adv;

  always_comb begin
    rdy[NSTAGE-1] = !vld_r[NSTAGE-1] || out_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vld_nxt[0] = rdy[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NSTAGE; k++) begin
      vld_nxt[k] = rdy[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign adv.a = rdy[0];
  assign adv.b = rdy[1];
  assign adv.c = rdy[2];

  logic [DAYS_W-1:0] days;
  logic              date_ok;

  cde_day_count u_days (
    .clk          (clk),
    .adv          (adv),
    .year         (in_data.year),
    .month        (in_data.month),
    .day_of_month (in_data.day_of_month),
    .days         (days),
    .date_ok      (date_ok)
  );

  // time of day rides alongside the day count
  logic [HMS_W-1:0] hms_a_r, hms_b_r, hms_c_r;
  logic             hok_a_r, hok_b_r, hok_c_r;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      hms_a_r <= HMS_W'(in_data.hour) * HMS_W'(SECS_PER_HOUR) +
                 HMS_W'(in_data.minute) * HMS_W'(SECS_PER_MIN) + HMS_W'(in_data.second);
      hok_a_r <= (in_data.hour <= HOUR_MAX) && (in_data.minute <= MINSEC_MAX) &&
                 (in_data.second <= MINSEC_MAX);
    end
    if (rdy[1]) begin
      hms_b_r <= hms_a_r;
      hok_b_r <= hok_a_r;
    end
    if (rdy[2]) begin
      hms_c_r <= hms_b_r;
      hok_c_r <= hok_b_r;
    end
  end

  // stage d: days to seconds
  logic [SECS_W-1:0] day_secs_d_r;
  logic [HMS_W-1:0]  hms_d_r;
  logic              ok_d_r;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      day_secs_d_r <= SECS_W'(days) * SECS_W'(SECS_PER_DAY);
      hms_d_r      <= hms_c_r;
      ok_d_r       <= date_ok && hok_c_r;
    end
  end

  // stage e: output register
  cde_out_t out_r;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      out_r.epoch_seconds <= ok_d_r ? day_secs_d_r + SECS_W'(hms_d_r) : '0;
      out_r.invalid       <= !ok_d_r;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[NSTAGE-1];
  assign out_data  = out_r;

endmodule

### src/cde_day_count.sv
// three-stage day count since the epoch from year, month and day, with date check
// depends on cde_pkg
module cde_day_count (
  input  logic                       clk,
  input  cde_pkg::cde_adv_t          adv,
  input  logic [15:0]                year,
  input  logic [7:0]                 month,
  input  logic [7:0]                 day_of_month,
  output logic [cde_pkg::DAYS_W-1:0] days,
  output logic                       date_ok
);
  import cde_pkg::*;

  // stage a: reciprocal multiplies for the divide by 25
  logic [15:0] prev_year;
  logic [29:0] p100_prod;
  logic [27:0] p400_prod;
  logic [29:0] y100_prod;
  logic [27:0] y400_prod;

  logic [15:0] year_a_r;
  logic [7:0]  month_a_r;
  logic [7:0]  day_a_r;
  logic [13:0] p4_a_r;
  logic [13:0] y4_a_r;
  logic [11:0] y16_a_r;
  logic [9:0]  q_p100_a_r;
  logic [7:0]  q_p400_a_r;
  logic [9:0]  q_y100_a_r;
  logic [7:0]  q_y400_a_r;
  logic        ok_a_r;

  assign prev_year = year - 16'd1;
  assign p100_prod = 30'(prev_year[15:2]) * 30'(RECIP25);
  assign p400_prod = 28'(prev_year[15:4]) * 28'(RECIP25);
  assign y100_prod = 30'(year[15:2]) * 30'(RECIP25);
  assign y400_prod = 28'(year[15:4]) * 28'(RECIP25);

  always_ff @(posedge clk) begin
    if (adv.a) begin
      year_a_r   <= year;
      month_a_r  <= month;
      day_a_r    <= day_of_month;
      p4_a_r     <= prev_year[15:2];
      y4_a_r     <= year[15:2];
      y16_a_r    <= year[15:4];
      q_p100_a_r <= p100_prod[RECIP25_SHIFT +: 10];
      q_p400_a_r <= p400_prod[RECIP25_SHIFT +: 8];
      q_y100_a_r <= y100_prod[RECIP25_SHIFT +: 10];
      q_y400_a_r <= y400_prod[RECIP25_SHIFT +: 8];
      ok_a_r     <= (year >= EPOCH_YEAR) && (month >= MONTH_JAN) &&
                    (month <= MONTH_DEC) && (day_of_month != 8'd0);
    end
  end

  // stage b: leap rule, leap count, day of year
  logic [13:0] rem100;
  logic [11:0] rem400;
  logic        leap;
  logic [13:0] leaps;
  logic [4:0]  mlen;
  logic [8:0]  doy;

  logic [15:0] yoff_b_r;
  logic [13:0] leaps_b_r;
  logic [8:0]  doy_b_r;
  logic        ok_b_r;

  always_comb begin
    rem100 = y4_a_r - 14'(q_y100_a_r) * 14'(DIV25);
    rem400 = y16_a_r - 12'(q_y400_a_r) * 12'(DIV25);
    leap   = (year_a_r[1:0] == 2'd0) &&
             ((rem100 != 14'd0) || ((year_a_r[3:0] == 4'd0) && (rem400 == 12'd0)));
    leaps  = p4_a_r - 14'(q_p100_a_r) + 14'(q_p400_a_r) - LEAPS_BEFORE_EPOCH;
    mlen   = month_len(month_a_r[3:0]) + 5'((month_a_r == MONTH_FEB) && leap);
    doy    = days_before_month(month_a_r[3:0]) + 9'((month_a_r > MONTH_FEB) && leap) +
             9'(day_a_r) - 9'd1;
  end

  always_ff @(posedge clk) begin
    if (adv.b) begin
      yoff_b_r  <= year_a_r - EPOCH_YEAR;
      leaps_b_r <= leaps;
      doy_b_r   <= doy;
      ok_b_r    <= ok_a_r && (day_a_r <= 8'(mlen));
    end
  end

  // stage c: whole days since the epoch
  logic [DAYS_W-1:0] days_c_r;
  logic              ok_c_r;

  always_ff @(posedge clk) begin
    if (adv.c) begin
      days_c_r <= DAYS_W'(yoff_b_r) * DAYS_W'(DAYS_PER_YEAR) + DAYS_W'(leaps_b_r) +
                  DAYS_W'(doy_b_r);
      ok_c_r   <= ok_b_r;
    end
  end

  assign days    = days_c_r;
  assign date_ok = ok_c_r;

endmodule

### tb/tb_calendar_date_to_epoch_seconds.sv
// testbench for calendar_date_to_epoch_seconds: directed and random dates through the
// valid/ready pipe, each result checked in order against an in-bench calendar predictor
// depends on cde_pkg and the calendar_date_to_epoch_seconds rtl
`timescale 1ns / 100ps

module tb_calendar_date_to_epoch_seconds;
  import cde_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned RANDOM_DATES  = 950;
  localparam int unsigned DRAIN_CYCLES  = 20;
  localparam int unsigned IDLE_PERCENT  = 34;

  class calendar_board;
    cde_out_t    expected_stamps[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned rejected;

    static function bit is_leap(int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    static function int unsigned month_days(int unsigned m, bit leap);
      case (m)
        2:           return leap ? 29 : 28;
        4, 6, 9, 11: return 30;
        default:     return 31;
      endcase
    endfunction

    // leap years in 1 .. y-1
    static function longint unsigned leaps_upto(int unsigned y);
      longint unsigned p;
      p = y - 1;
      return p / 4 - p / 100 + p / 400;
    endfunction

    function cde_out_t predict_stamp(cde_in_t d);
      cde_out_t        r;
      bit              ok;
      bit              leap;
      int unsigned     y;
      int unsigned     m;
      int unsigned     dd;
      longint unsigned days;
      longint unsigned secs;
      y    = d.year;
      m    = d.month;
      dd   = d.day_of_month;
      leap = is_leap(y);
      ok = (y >= 1970) && (m >= 1) && (m <= 12) && (dd >= 1) &&
           (d.hour <= 23) && (d.minute <= 59) && (d.second <= 59);
      if (ok && dd > month_days(m, leap)) ok = 0;
      r.epoch_seconds = '0;
      r.invalid       = 1'b1;
      if (!ok) return r;
      days = longint'(365) * (y - 1970) + leaps_upto(y) - leaps_upto(1970);
      for (int unsigned i = 1; i < m; i++) days += month_days(i, leap);
      days += dd - 1;
      secs = days * 86400 + longint'(d.hour) * 3600 + longint'(d.minute) * 60 +
             longint'(d.second);
      r.epoch_seconds = secs[SECS_W-1:0];
      r.invalid       = 1'b0;
      return r;
    endfunction

    function void note_date(cde_in_t d);
      expected_stamps.push_back(predict_stamp(d));
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
      mismatches++;
      $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    task check_stamp(cde_out_t got);
      cde_out_t want;
      if (expected_stamps.size() == 0) begin
        report("unexpected result beat, epoch_seconds", got.epoch_seconds, 0);
      end else begin
        want = expected_stamps.pop_front();
        checked++;
        if (want.invalid) rejected++;
        if (got.epoch_seconds !== want.epoch_seconds)
          report("epoch_seconds", got.epoch_seconds, want.epoch_seconds);
        if (got.invalid !== want.invalid)
          report("invalid", got.invalid, want.invalid);
      end
    endtask

    function int pending();
      return expected_stamps.size();
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  cde_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  cde_out_t out_data;

  calendar_board board;
  bit            idling;
  int unsigned   cycle_count;
  int unsigned   dates_sent;

  calendar_date_to_epoch_seconds u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               board.pending());
      $display("[calendar_date_to_epoch_seconds] ERROR");
      $finish;
    end
  end

  // accepted beats on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) board.note_date(in_data);
      if (out_valid && out_ready) board.check_stamp(out_data);
    end
  end

  always @(negedge clk) begin
    out_ready <= idling ? ($urandom_range(0, 99) >= IDLE_PERCENT) : 1'b1;
  end

  task send_date(input cde_in_t d);
    @(negedge clk);
    while (idling && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    dates_sent++;
  endtask

  task send_fields(input int unsigned y, input int unsigned mo, input int unsigned dd,
                   input int unsigned h, input int unsigned mi, input int unsigned s);
    cde_in_t d;
    d.year         = y[15:0];
    d.month        = mo[7:0];
    d.day_of_month = dd[7:0];
    d.hour         = h[7:0];
    d.minute       = mi[7:0];
    d.second       = s[7:0];
    send_date(d);
  endtask

  function automatic cde_in_t make_valid_date(bit wide_years);
    cde_in_t     d;
    int unsigned y;
    int unsigned m;
    y = wide_years ? $urandom_range(1970, 65535) : $urandom_range(1970, 2110);
    m = $urandom_range(1, 12);
    d.year         = y[15:0];
    d.month        = m[7:0];
    d.day_of_month = 8'($urandom_range(1,
                        calendar_board::month_days(m, calendar_board::is_leap(y))));
    d.hour         = 8'($urandom_range(0, 23));
    d.minute       = 8'($urandom_range(0, 59));
    d.second       = 8'($urandom_range(0, 59));
    return d;
  endfunction

  // valid date with one field pushed to or just past its limit
  function automatic cde_in_t make_edge_date();
    cde_in_t     d;
    int unsigned mlen;
    d    = make_valid_date($urandom_range(0, 3) == 0);
    mlen = calendar_board::month_days(d.month, calendar_board::is_leap(d.year));
    case ($urandom_range(0, 6))
      0: d.day_of_month = 8'(mlen + $urandom_range(0, 1));
      1: begin
        d.month        = 8'd2;
        d.day_of_month = 8'd29;
      end
      2: d.hour   = 8'($urandom_range(23, 24));
      3: d.minute = 8'($urandom_range(59, 60));
      4: d.second = 8'($urandom_range(59, 60));
      5: d.year   = 16'($urandom_range(1969, 1970));
      default: d.month = $urandom_range(0, 1) ? 8'd0 : 8'd13;
    endcase
    return d;
  endfunction

  function automatic cde_in_t make_noise_date();
    cde_in_t d;
    d.year         = 16'($urandom_range(0, 65535));
    d.month        = 8'($urandom_range(0, 255));
    d.day_of_month = 8'($urandom_range(0, 255));
    d.hour         = 8'($urandom_range(0, 255));
    d.minute       = 8'($urandom_range(0, 255));
    d.second       = 8'($urandom_range(0, 255));
    return d;
  endfunction

  initial begin
    int unsigned pick;
    board       = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_ready   = 1'b0;
    idling      = 1'b1;
    cycle_count = 0;
    dates_sent  = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed dates
    send_fields(1970, 1, 1, 0, 0, 0);
    send_fields(65535, 12, 31, 23, 59, 59);
    send_fields(1969, 12, 31, 23, 59, 59);
    send_fields(0, 1, 1, 0, 0, 0);
    send_fields(2038, 1, 19, 3, 14, 8);
    send_fields(2000, 2, 29, 12, 0, 0);
    send_fields(1900, 2, 29, 0, 0, 0);
    send_fields(2100, 2, 29, 0, 0, 0);
    send_fields(2024, 2, 29, 6, 30, 15);
    send_fields(2024, 2, 30, 0, 0, 0);
    send_fields(2023, 2, 29, 0, 0, 0);
    send_fields(2000, 3, 1, 0, 0, 0);
    send_fields(2400, 12, 31, 23, 59, 59);
    send_fields(1999, 0, 10, 0, 0, 0);
    send_fields(1999, 13, 10, 0, 0, 0);
    send_fields(1999, 255, 10, 0, 0, 0);
    send_fields(1999, 5, 0, 0, 0, 0);
    send_fields(1999, 1, 32, 0, 0, 0);
    send_fields(1999, 4, 31, 0, 0, 0);
    send_fields(1999, 4, 30, 23, 59, 59);
    send_fields(1999, 6, 15, 24, 0, 0);
    send_fields(1999, 6, 15, 0, 60, 0);
    send_fields(1999, 6, 15, 0, 0, 60);
    send_fields(65535, 255, 255, 255, 255, 255);
    send_fields(1970, 12, 31, 0, 0, 0);

    // random dates, with a long stretch of back-to-back traffic in the middle
    for (int unsigned n = 0; n < RANDOM_DATES; n++) begin
      idling = !(n >= 350 && n < 550);
      pick   = $urandom_range(0, 99);
      if (pick < 60)      send_date(make_valid_date(1'b0));
      else if (pick < 75) send_date(make_valid_date(1'b1));
      else if (pick < 88) send_date(make_edge_date());
      else                send_date(make_noise_date());
    end
    @(negedge clk);
    in_valid <= 1'b0;
    idling = 1'b1;

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d dates, checked %0d results (%0d flagged invalid)", dates_sent,
             board.checked, board.rejected);
    $display("mismatches: %0d", board.mismatches);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("[calendar_date_to_epoch_seconds] OK");
    end else begin
      $display("[calendar_date_to_epoch_seconds] ERROR");
    end
    $finish;
  end

endmodule
